// ===== rtl/kpht_pkg.sv =====
// ----------------------------------------------------------------------------
// kpht_pkg
// Shared widths, key state codes, register indexes and the slot chain link.
// ----------------------------------------------------------------------------
package kpht_pkg;

   localparam int KEY_W    = 5;
   localparam int SLOT_W   = 4;
   localparam int STATE_W  = 3;
   localparam int BITMAP_W = 18;
   localparam int TIME_W   = 32;
   localparam int CFG_W    = 16;
   localparam int IDX_W    = 2;

   localparam logic [KEY_W-1:0] EMPTY_KEY = 5'd31;

   localparam logic [STATE_W-1:0] ST_IDLE        = 3'd0;
   localparam logic [STATE_W-1:0] ST_PRESSED     = 3'd1;
   localparam logic [STATE_W-1:0] ST_HOLD_SHORT  = 3'd2;
   localparam logic [STATE_W-1:0] ST_HOLD_NORMAL = 3'd3;
   localparam logic [STATE_W-1:0] ST_HOLD_LONG   = 3'd4;
   localparam logic [STATE_W-1:0] ST_RELEASED    = 3'd5;

   localparam logic [IDX_W-1:0] REG_DEBOUNCE    = 2'd0;
   localparam logic [IDX_W-1:0] REG_SHORT_HOLD  = 2'd1;
   localparam logic [IDX_W-1:0] REG_NORMAL_HOLD = 2'd2;
   localparam logic [IDX_W-1:0] REG_LONG_HOLD   = 2'd3;

   // hold threshold compares, computed once and broadcast to every cell
   typedef struct packed {
      logic gt_short;
      logic gt_normal;
      logic gt_long;
   } hold_cmp_type;

   // passed from cell to cell along the slot row
   typedef struct packed {
      logic               free;   // an earlier slot is empty
      logic               match;  // an earlier slot holds the visited key
      logic               emit;   // an earlier slot changed state
      logic [SLOT_W-1:0]  slot;
      logic [STATE_W-1:0] state;
   } link_type;

endpackage

// ===== rtl/kpht_cell.sv =====
// ----------------------------------------------------------------------------
// kpht_cell
// One list slot: holds its key code and key state, advances when visited.
// ----------------------------------------------------------------------------
module kpht_cell #(
   parameter int SLOT_IDX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          step_en,
   input  logic [kpht_pkg::KEY_W-1:0]    code,
   input  logic                          closed,
   input  logic                          found_any,
   input  kpht_pkg::hold_cmp_type        cmp,
   input  kpht_pkg::link_type            link_in,
   output kpht_pkg::link_type            link_out
);

   logic [kpht_pkg::KEY_W-1:0]   key_ff;
   logic [kpht_pkg::STATE_W-1:0] state_ff;
   logic [kpht_pkg::STATE_W-1:0] cur_state;
   logic [kpht_pkg::STATE_W-1:0] state_in;
   logic                         is_empty;
   logic                         my_match;
   logic                         alloc;
   logic                         change;
   logic                         my_emit;

   assign is_empty = (key_ff == kpht_pkg::EMPTY_KEY);
   assign my_match = (key_ff == code);
   // first empty slot takes a newly closed key that no slot holds
   assign alloc     = !found_any && closed && is_empty && !link_in.free;
   assign cur_state = alloc ? kpht_pkg::ST_IDLE : state_ff;

   always_comb begin
      state_in = cur_state;
      change   = 1'b0;
      unique case (cur_state)
         kpht_pkg::ST_IDLE: begin
            if (closed) begin
               state_in = kpht_pkg::ST_PRESSED;
               change   = 1'b1;
            end
         end
         kpht_pkg::ST_PRESSED: begin
            if (cmp.gt_short) begin
               state_in = kpht_pkg::ST_HOLD_SHORT;
               change   = 1'b1;
            end else if (!closed) begin
               state_in = kpht_pkg::ST_RELEASED;
               change   = 1'b1;
            end
         end
         kpht_pkg::ST_HOLD_SHORT: begin
            if (cmp.gt_normal) begin
               state_in = kpht_pkg::ST_HOLD_NORMAL;
               change   = 1'b1;
            end else if (!closed) begin
               state_in = kpht_pkg::ST_RELEASED;
               change   = 1'b1;
            end
         end
         kpht_pkg::ST_HOLD_NORMAL: begin
            if (cmp.gt_long) begin
               state_in = kpht_pkg::ST_HOLD_LONG;
               change   = 1'b1;
            end else if (!closed) begin
               state_in = kpht_pkg::ST_RELEASED;
               change   = 1'b1;
            end
         end
         kpht_pkg::ST_HOLD_LONG: begin
            if (!closed) begin
               state_in = kpht_pkg::ST_RELEASED;
               change   = 1'b1;
            end
         end
         kpht_pkg::ST_RELEASED: begin
            state_in = kpht_pkg::ST_IDLE;
            change   = 1'b1;
         end
         default: begin
            state_in = cur_state;
            change   = 1'b0;
         end
      endcase
   end

   assign my_emit = (my_match || alloc) && change;

   always_comb begin
      link_out.free  = link_in.free || is_empty;
      link_out.match = link_in.match || my_match;
      link_out.emit  = link_in.emit || my_emit;
      link_out.slot  = my_emit ? kpht_pkg::SLOT_W'(SLOT_IDX) : link_in.slot;
      link_out.state = my_emit ? state_in : link_in.state;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= kpht_pkg::EMPTY_KEY;
         state_ff <= kpht_pkg::ST_IDLE;
      end else if (clear) begin
         if (state_ff == kpht_pkg::ST_IDLE) key_ff <= kpht_pkg::EMPTY_KEY;
      end else if (step_en && my_emit) begin
         state_ff <= state_in;
         if (alloc) key_ff <= code;
      end
   end

endmodule

// ===== rtl/keypad_key_list_hold_tracker.sv =====
// ----------------------------------------------------------------------------
// keypad_key_list_hold_tracker
// Keypad active-key list with debounce and shared hold timing.
// ----------------------------------------------------------------------------
// A scan item is taken only while the block is idle. If it falls inside the
// debounce window it is dropped there and then; otherwise the idle slots are
// emptied in that same cycle and the min(KEY_ROWS*KEY_COLS, 18) key codes are
// visited one per cycle, each visit looking up all LIST_SLOTS slot cells at
// once; a visit that yields a new result waits while the held result cannot
// move on because the output register is full and rsp_ready is low.
// Results leave in slot-change order through a one-item holding stage, which
// is what lets the final result of a scan carry rsp_last. Configuration writes
// are always taken; a debounce write of zero stores one.
// ----------------------------------------------------------------------------
module keypad_key_list_hold_tracker #(
   parameter int KEY_ROWS   = 6,
   parameter int KEY_COLS   = 3,
   parameter int LIST_SLOTS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [kpht_pkg::TIME_W-1:0]       req_now_ms,
   input  logic [kpht_pkg::BITMAP_W-1:0]     req_key_closed_bits,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [kpht_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [kpht_pkg::KEY_W-1:0]        rsp_key_code,
   output logic [kpht_pkg::STATE_W-1:0]      rsp_new_state,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kpht_pkg::IDX_W-1:0]        csr_index,
   input  logic [kpht_pkg::CFG_W-1:0]        csr_data
);

   localparam int NKEYS = (KEY_ROWS * KEY_COLS > kpht_pkg::BITMAP_W) ?
                          kpht_pkg::BITMAP_W : KEY_ROWS * KEY_COLS;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_VISIT = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;

   logic [1:0]                       fsm_ff;
   logic [kpht_pkg::CFG_W-1:0]       debounce_ff;
   logic [kpht_pkg::CFG_W-1:0]       short_ff;
   logic [kpht_pkg::CFG_W-1:0]       normal_ff;
   logic [kpht_pkg::CFG_W-1:0]       long_ff;
   logic [kpht_pkg::TIME_W-1:0]      last_scan_ff;
   logic [kpht_pkg::TIME_W-1:0]      hold_start_ff;
   logic [kpht_pkg::TIME_W-1:0]      now_ff;
   logic [kpht_pkg::BITMAP_W-1:0]    bits_ff;
   logic [kpht_pkg::KEY_W-1:0]       code_ff;

   logic                             pend_valid_ff;
   logic [kpht_pkg::SLOT_W-1:0]      pend_slot_ff;
   logic [kpht_pkg::KEY_W-1:0]       pend_key_ff;
   logic [kpht_pkg::STATE_W-1:0]     pend_state_ff;

   logic                             rsp_valid_ff;
   logic [kpht_pkg::SLOT_W-1:0]      rsp_slot_ff;
   logic [kpht_pkg::KEY_W-1:0]       rsp_key_ff;
   logic [kpht_pkg::STATE_W-1:0]     rsp_state_ff;
   logic                             rsp_last_ff;

   logic                             req_fire;
   logic                             scan_ok;
   logic [kpht_pkg::TIME_W-1:0]      since_scan;
   logic [kpht_pkg::TIME_W-1:0]      held;
   logic                             visiting;
   logic                             closed;
   logic                             out_free;
   logic                             step_en;
   logic                             emit;
   logic                             last_code;
   logic                             push_mid;
   logic                             push_last;
   logic [kpht_pkg::CFG_W-1:0]       debounce_in;
   kpht_pkg::hold_cmp_type           cmp;
   kpht_pkg::link_type               links [LIST_SLOTS+1];

   assign req_ready = (fsm_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign since_scan = req_now_ms - last_scan_ff;
   assign scan_ok    = since_scan > {{(kpht_pkg::TIME_W-kpht_pkg::CFG_W){1'b0}}, debounce_ff};

   assign held          = now_ff - hold_start_ff;
   assign cmp.gt_short  = held > {{(kpht_pkg::TIME_W-kpht_pkg::CFG_W){1'b0}}, short_ff};
   assign cmp.gt_normal = held > {{(kpht_pkg::TIME_W-kpht_pkg::CFG_W){1'b0}}, normal_ff};
   assign cmp.gt_long   = held > {{(kpht_pkg::TIME_W-kpht_pkg::CFG_W){1'b0}}, long_ff};

   assign visiting  = (fsm_ff == S_VISIT);
   assign closed    = bits_ff[code_ff];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = links[LIST_SLOTS].emit;
   // a new result bumps the held one out, which needs room downstream
   assign step_en   = visiting && !(emit && pend_valid_ff && !out_free);
   assign last_code = (code_ff == kpht_pkg::KEY_W'(NKEYS - 1));
   assign push_mid  = step_en && emit && pend_valid_ff;
   assign push_last = (fsm_ff == S_FLUSH) && pend_valid_ff && out_free;

   assign links[0] = '0;

   for (genvar g = 0; g < LIST_SLOTS; g++) begin : g_cell
      kpht_cell #(
         .SLOT_IDX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .clear     (req_fire && scan_ok),
         .step_en   (step_en),
         .code      (code_ff),
         .closed    (closed),
         .found_any (links[LIST_SLOTS].match),
         .cmp       (cmp),
         .link_in   (links[g]),
         .link_out  (links[g+1])
      );
   end

   assign debounce_in = (csr_data == '0) ? kpht_pkg::CFG_W'(1) : csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= 16'd20;
         short_ff    <= 16'd500;
         normal_ff   <= 16'd1000;
         long_ff     <= 16'd2000;
      end else if (csr_valid) begin
         unique case (csr_index)
            kpht_pkg::REG_DEBOUNCE:    debounce_ff <= debounce_in;
            kpht_pkg::REG_SHORT_HOLD:  short_ff    <= csr_data;
            kpht_pkg::REG_NORMAL_HOLD: normal_ff   <= csr_data;
            kpht_pkg::REG_LONG_HOLD:   long_ff     <= csr_data;
            default:                   debounce_ff <= debounce_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= S_IDLE;
         last_scan_ff  <= '0;
         hold_start_ff <= '0;
         code_ff       <= '0;
      end else begin
         unique case (fsm_ff)
            S_IDLE: begin
               if (req_fire && scan_ok) begin
                  fsm_ff       <= S_VISIT;
                  last_scan_ff <= req_now_ms;
                  code_ff      <= '0;
               end
            end
            S_VISIT: begin
               if (step_en) begin
                  // any new press restarts the shared hold timer
                  if (emit && links[LIST_SLOTS].state == kpht_pkg::ST_PRESSED)
                     hold_start_ff <= now_ff;
                  if (last_code) fsm_ff <= S_FLUSH;
                  else code_ff <= code_ff + kpht_pkg::KEY_W'(1);
               end
            end
            S_FLUSH: begin
               if (!pend_valid_ff || out_free) fsm_ff <= S_IDLE;
            end
            default: fsm_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         now_ff  <= req_now_ms;
         bits_ff <= req_key_closed_bits;
      end
   end

   // holding stage: a result is known to be final only once the scan ends
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (step_en && emit) begin
         pend_valid_ff <= 1'b1;
      end else if (push_last) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && emit) begin
         pend_slot_ff  <= links[LIST_SLOTS].slot;
         pend_key_ff   <= code_ff;
         pend_state_ff <= links[LIST_SLOTS].state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push_mid || push_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_mid || push_last) begin
         rsp_slot_ff  <= pend_slot_ff;
         rsp_key_ff   <= pend_key_ff;
         rsp_state_ff <= pend_state_ff;
         rsp_last_ff  <= push_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_key_code  = rsp_key_ff;
   assign rsp_new_state = rsp_state_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
